// ===== design/signed_binary_to_decimal_ascii_core_assert.svh =====
// Assertion macros for the converter core.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define S2D_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define S2D_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define S2D_ASSERT(name, clk, rst, prop, msg)
`define S2D_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

// ===== design/s2d_pkg.sv =====
// Types and constants for the signed binary to decimal ASCII converter.
package s2d_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BCD_W   = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // A decimal digit of five or more is corrected by three before doubling.
  localparam logic [BCD_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [BCD_W-1:0] DABBLE_ADD = 4'd3;

  // Per-cycle command to every digit cell.
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // correct and shift one binary bit in
    logic move;    // take the digit of the lower neighbor
  } cell_ctl_t;

endpackage

// ===== design/s2d_in_if.sv =====
// Input channel: one signed binary word per handshake.
interface s2d_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [s2d_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== design/s2d_out_if.sv =====
// Output channel: one ASCII character per handshake.
interface s2d_out_if;
  logic                         valid;
  logic                         ready;
  logic [s2d_pkg::CHAR_W-1:0]   char_byte;
  logic                         last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

// ===== design/signed_binary_to_decimal_ascii_core.sv =====
// Top level: signed binary word in, decimal ASCII characters out.
//
//  channel  dir  fields                      meaning
//  num      in   value[63:0]                 signed integer, low VALUE_BITS bits used
//  text     out  char_byte[7:0], last_char   one character, last_char on the final one
//
// Each word is loaded, passes through VALUE_BITS shift-add-3 steps in the
// digit chain and has its leading zeros shifted out (at least one digit stays);
// then one character per cycle (a minus sign plus the digits) while text is ready.
// One word is converted at a time; num.ready is high only when idle.
// Reset is synchronous and returns the block to idle; stalls on text hold
// the current character until taken.
module signed_binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  s2d_in_if.sink     num,
  s2d_out_if.source  text
);

  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t                    state;
  logic [VALUE_BITS-1:0]     mag;
  logic                      neg;
  logic [BIT_CNT_W-1:0]      bit_cnt;
  logic [DIG_CNT_W-1:0]      dig_cnt;

  logic [VALUE_BITS-1:0]     in_bits;
  logic                      in_neg;
  s2d_pkg::cell_ctl_t        ctl;
  logic [s2d_pkg::BCD_W-1:0] digits [NUM_DIGITS];
  logic                      carry  [NUM_DIGITS];
  logic [s2d_pkg::BCD_W-1:0] top_digit;
  logic                      top_zero;
  logic                      top_carry;
  logic                      num_acc;
  logic                      text_acc;

  assign in_bits   = num.value[VALUE_BITS-1:0];
  assign in_neg    = in_bits[VALUE_BITS-1];
  assign top_digit = digits[NUM_DIGITS-1];
  assign top_zero  = (top_digit == '0);
  assign top_carry = carry[NUM_DIGITS-1];
  assign num_acc   = num.valid && num.ready;
  assign text_acc  = text.valid && text.ready;

  // Drive the handshakes and the current character
  assign num.ready      = (state == ST_IDLE);
  assign text.valid     = (state == ST_SIGN) || (state == ST_EMIT);
  assign text.char_byte = (state == ST_SIGN) ? s2d_pkg::ASCII_MINUS
                          : s2d_pkg::CHAR_W'(s2d_pkg::ASCII_ZERO
                                             + s2d_pkg::CHAR_W'(top_digit));
  assign text.last_char = (state == ST_EMIT) && (dig_cnt == DIG_CNT_W'(1));

  // Command the digit chain
  always_comb begin
    ctl.clear  = num_acc;
    ctl.dabble = (state == ST_CONVERT);
    ctl.move   = ((state == ST_SKIP) && top_zero && (dig_cnt != DIG_CNT_W'(1)))
                 || ((state == ST_EMIT) && text.ready);
  end

  // Build the chain: binary bits enter at the low digit, digits move up
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    s2d_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .carry_in  ((i == 0) ? mag[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1]),
      .digit_in  ((i == 0) ? '0 : digits[(i == 0) ? 0 : i-1]),
      .carry_out (carry[i]),
      .digit     (digits[i])
    );
  end

  // Sequence load, conversion, zero skipping and character output
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mag     <= '0;
      neg     <= 1'b0;
      bit_cnt <= '0;
      dig_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (num_acc) begin
            neg     <= in_neg;
            mag     <= in_neg ? VALUE_BITS'(~in_bits + 1'b1) : in_bits;
            bit_cnt <= BIT_CNT_W'(VALUE_BITS);
            state   <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          mag     <= {mag[VALUE_BITS-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == BIT_CNT_W'(1)) begin
            dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
            state   <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_zero && (dig_cnt != DIG_CNT_W'(1))) begin
            dig_cnt <= dig_cnt - 1'b1;
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (text_acc) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (text_acc) begin
            dig_cnt <= dig_cnt - 1'b1;
            if (dig_cnt == DIG_CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `include "signed_binary_to_decimal_ascii_core_assert.svh"

  `S2D_ASSERT_NEVER(a_no_overlap, clk, rst, num.ready && text.valid, "input taken during output")
  `S2D_ASSERT(a_last_ends, clk, rst, text_acc && text.last_char |=> !text.valid, "text after last")
  `S2D_ASSERT(a_minus_neg, clk, rst, (state == ST_SIGN) |-> neg, "minus for positive value")
  `S2D_ASSERT_NEVER(a_top_carry, clk, rst, (state == ST_CONVERT) && top_carry, "digit overflow")
  `S2D_ASSERT(a_cnt_live, clk, rst, text.valid |-> (dig_cnt != '0), "count empty in output")

endmodule

// ===== design/s2d_cell.sv =====
// One decimal digit cell of the shift-add-3 chain.
module s2d_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  s2d_pkg::cell_ctl_t          ctl,
  input  logic                        carry_in,
  input  logic [s2d_pkg::BCD_W-1:0]   digit_in,
  output logic                        carry_out,
  output logic [s2d_pkg::BCD_W-1:0]   digit
);

  logic [s2d_pkg::BCD_W-1:0] adj;

  // Correct the digit so that doubling carries into the next decade
  always_comb begin
    adj = (digit >= s2d_pkg::DABBLE_MIN) ? digit + s2d_pkg::DABBLE_ADD : digit;
  end

  assign carry_out = adj[s2d_pkg::BCD_W-1];

  // Hold, clear, shift a bit in, or take the neighbor's digit
  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= '0;
    end else if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.dabble) begin
      digit <= {adj[s2d_pkg::BCD_W-2:0], carry_in};
    end else if (ctl.move) begin
      digit <= digit_in;
    end
  end

endmodule
